>>> src/mtfr_pkg.sv
// Shared types, constants and sizes for the two-four-one perceptron unit.
package mtfr_pkg;

  localparam int NUM_HIDDEN  = 4;
  localparam int FRAC_BITS   = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] REG_HID_FIRST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW   = CFG_IDX_W'(NUM_HIDDEN);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_TOP   = CFG_IDX_W'(NUM_HIDDEN + 1);

  typedef struct packed {
    logic signed [15:0] feature_a;
    logic signed [15:0] feature_b;
  } item_t;

  typedef struct packed {
    logic signed [15:0] prediction;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [NUM_HIDDEN-1:0][15:0] hid_bias;
    logic [NUM_HIDDEN-1:0][15:0] hid_wa;
    logic [NUM_HIDDEN-1:0][15:0] hid_wb;
    logic [NUM_HIDDEN-1:0][15:0] out_w;
    logic [15:0]                 out_bias;
  } weights_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> src/mtfr_front.sv
// Input register stage that takes items and hands them to the queue.
module mtfr_front
  import mtfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  queue_full,
  output logic  push,
  output item_t push_item
);

  logic  hold_valid;
  logic  hold_valid_next;
  item_t hold;
  logic  take;

  assign item_stall      = hold_valid && queue_full;
  assign take            = item_valid && !item_stall;
  assign push            = hold_valid && !queue_full;
  assign push_item       = hold;
  assign hold_valid_next = take || (hold_valid && queue_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= item;
    end
  end

endmodule

>>> src/mtfr_queue.sv
// Short first-in first-out queue between the front and back parts.
module mtfr_queue
  import mtfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  item_t         push_item,
  input  logic          pop,
  output item_t         head,
  output queue_status_t status
);

  item_t              entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/mtfr_back.sv
// Four-stage datapath that evaluates the hidden layer and the output neuron.
module mtfr_back
  import mtfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  weights_t weights,
  input  item_t    head,
  input  logic     head_valid,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  localparam int ACC_W = 35;

  function automatic logic [16:0] sat16(input logic signed [ACC_W-1:0] x);
    logic in_range;
    begin
      in_range = (&x[ACC_W-1:15]) || !(|x[ACC_W-1:15]);
      if (in_range) begin
        sat16 = {1'b0, x[15:0]};
      end else begin
        sat16 = {1'b1, x[ACC_W-1] ? 16'h8000 : 16'h7fff};
      end
    end
  endfunction

  logic adv;
  logic v1, v2, v3;

  logic signed [31:0] s1_pa [NUM_HIDDEN];
  logic signed [31:0] s1_pb [NUM_HIDDEN];

  logic [15:0]        s2_h [NUM_HIDDEN];
  logic               s2_flag;
  logic [15:0]        h_next [NUM_HIDDEN];
  logic               flag_next;

  logic signed [31:0] s3_q [NUM_HIDDEN];
  logic               s3_flag;

  logic [16:0]        out_sat;

  assign adv = !result_valid || !result_stall;
  assign pop = adv && head_valid;

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic [16:0]             sv;
    flag_next = 1'b0;
    for (int j = 0; j < NUM_HIDDEN; j++) begin
      acc = (ACC_W'($signed(weights.hid_bias[j])) <<< FRAC_BITS)
            + ACC_W'(s1_pa[j]) + ACC_W'(s1_pb[j]);
      sv  = sat16(acc >>> FRAC_BITS);
      flag_next = flag_next | sv[16];
      h_next[j] = sv[15] ? 16'h0000 : sv[15:0];
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] oacc;
    oacc = ACC_W'($signed(weights.out_bias)) <<< FRAC_BITS;
    for (int j = 0; j < NUM_HIDDEN; j++) begin
      oacc = oacc + ACC_W'(s3_q[j]);
    end
    out_sat = sat16(oacc >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= head_valid;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NUM_HIDDEN; j++) begin
        s1_pa[j] <= $signed(weights.hid_wa[j]) * head.feature_a;
        s1_pb[j] <= $signed(weights.hid_wb[j]) * head.feature_b;
        s2_h[j]  <= h_next[j];
        s3_q[j]  <= $signed(weights.out_w[j]) * $signed(s2_h[j]);
      end
      s2_flag           <= flag_next;
      s3_flag           <= s2_flag;
      result.prediction <= out_sat[15:0];
      result.saturated  <= s3_flag | out_sat[16];
    end
  end

endmodule

>>> src/mlp_two_four_one_relu_unit.sv
// Top level of the two-four-one perceptron unit with ReLU hidden layer.
//
//   Channel   Signals                              Transfer when
//   item      item_valid, item_stall, item         item_valid && !item_stall
//   result    result_valid, result_stall, result   result_valid && !result_stall
//   config    cfg_valid, cfg_ready, cfg_index/data cfg_valid && cfg_ready
//
// One item is taken per cycle while item_stall is low; each result passes through the
// input register, the queue and the four datapath stages after its transfer.
// Reset clears all weights to zero and empties every stage and the queue.
// A stalled result freezes the datapath; the queue of four plus the input
// register absorb items, and item_stall rises once both are full.
module mlp_two_four_one_relu_unit
  import mtfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  weights_t      weights;
  logic          push;
  item_t         push_item;
  logic          pop;
  item_t         head;
  queue_status_t q_status;
  logic          cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= '0;
    end else if (cfg_write) begin
      for (int j = 0; j < NUM_HIDDEN; j++) begin
        if (cfg_index == REG_HID_FIRST + CFG_IDX_W'(j)) begin
          weights.hid_bias[j] <= cfg_data[15:0];
          weights.hid_wa[j]   <= cfg_data[31:16];
          weights.hid_wb[j]   <= cfg_data[47:32];
        end
      end
      if (cfg_index == REG_OUT_LOW) begin
        weights.out_bias    <= cfg_data[15:0];
        weights.out_w[0]    <= cfg_data[31:16];
        weights.out_w[1]    <= cfg_data[47:32];
        weights.out_w[2]    <= cfg_data[63:48];
      end
      if (cfg_index == REG_OUT_TOP) begin
        weights.out_w[3]    <= cfg_data[15:0];
      end
    end
  end

  mtfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (q_status.full),
    .push       (push),
    .push_item  (push_item)
  );

  mtfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  mtfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .weights      (weights),
    .head         (head),
    .head_valid   (!q_status.empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("Queue written while full.");

  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("Queue read while empty.");

  a_no_pop_when_blocked : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !pop)
    else $error("Datapath advanced while the result was stalled.");

  a_stall_needs_full_queue : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> q_status.full)
    else $error("Input stalled although the queue had room.");

endmodule

>>> sim/mtfr_prediction_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each perceptron result from the item transfers and compares it.
module mtfr_prediction_checker
  import mtfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int HID_SEL_W = $clog2(NUM_HIDDEN);

  weights_t             net;
  result_t              expected_results[$];
  result_t              oldest;
  logic [HID_SEL_W-1:0] hid_sel;

  assign hid_sel = HID_SEL_W'(cfg_index - REG_HID_FIRST);

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic longint clip16(input longint v, inout bit hit);
    if (v > 32767) begin
      hit = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      hit = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic result_t run_network(input item_t x);
    longint  acc;
    longint  hval;
    longint  oacc;
    bit      hit;
    result_t r;
    hit = 1'b0;
    oacc = longint'($signed(net.out_bias)) * (longint'(1) << FRAC_BITS);
    for (int j = 0; j < NUM_HIDDEN; j++) begin
      acc = longint'($signed(net.hid_bias[j])) * (longint'(1) << FRAC_BITS)
          + longint'($signed(net.hid_wa[j])) * longint'(x.feature_a)
          + longint'($signed(net.hid_wb[j])) * longint'(x.feature_b);
      hval = clip16(acc >>> FRAC_BITS, hit);
      if (hval < 0) begin
        hval = 0;
      end
      oacc += longint'($signed(net.out_w[j])) * hval;
    end
    r.prediction = 16'(clip16(oacc >>> FRAC_BITS, hit));
    r.saturated  = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      net <= '0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OUT_LOW: begin
            net.out_bias <= cfg_data[15:0];
            net.out_w[0] <= cfg_data[31:16];
            net.out_w[1] <= cfg_data[47:32];
            net.out_w[2] <= cfg_data[63:48];
          end
          REG_OUT_TOP: begin
            net.out_w[NUM_HIDDEN-1] <= cfg_data[15:0];
          end
          default: begin
            if (cfg_index < REG_OUT_LOW) begin
              net.hid_bias[hid_sel] <= cfg_data[15:0];
              net.hid_wa[hid_sel]   <= cfg_data[31:16];
              net.hid_wb[hid_sel]   <= cfg_data[47:32];
            end
          end
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transfer", result.prediction, 0);
        end else begin
          oldest = expected_results.pop_front();
          if (result.prediction !== oldest.prediction) begin
            report_mismatch("prediction", result.prediction, oldest.prediction);
          end
          if (result.saturated !== oldest.saturated) begin
            report_mismatch("saturated", result.saturated, oldest.saturated);
          end
        end
      end
      if (item_valid && !item_stall) begin
        expected_results.push_back(run_network(item));
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

>>> sim/mlp_two_four_one_relu_unit_test.sv
`timescale 1ns / 1ps
// Stimulus, watchdog and verdict for the two-four-one perceptron unit.
module mlp_two_four_one_relu_unit_test;
  import mtfr_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_AFTER    = 400;
  localparam int HOLD_CYCLES   = 120;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CORNER_COUNT  = 14;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = REG_OUT_TOP + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = REG_OUT_TOP + CFG_IDX_W'(2);

  typedef enum int {
    WEIGHTS_FULL,
    WEIGHTS_UNIT,
    WEIGHTS_FINE,
    WEIGHTS_EDGE,
    WEIGHTS_MIXED
  } weight_style_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  item_t                 item         = '0;
  logic                  result_stall = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  item_stall;
  logic                  result_valid;
  result_t               result;
  logic                  cfg_ready;
  int                    mismatches;
  int                    outstanding;
  int                    idle_cycles  = 0;
  bit                    no_gaps      = 1'b0;

  logic [31:0] corner_items [CORNER_COUNT] = '{
    32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF,
    32'h0001_FFFF, 32'hFFFF_0001, 32'h1000_1000, 32'hF000_0800, 32'h0003_FFFB,
    32'h5555_AAAA, 32'hAAAA_5555, 32'h0FFF_F001, 32'hC000_3FFF
  };

  mlp_two_four_one_relu_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mtfr_prediction_checker prediction_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [15:0] random_weight(input weight_style_t style);
    case (style)
      WEIGHTS_FULL: return 16'($urandom);
      WEIGHTS_UNIT: return 16'($urandom_range(0, 8191) - 4096);
      WEIGHTS_FINE: return 16'($urandom_range(0, 2047) - 1024);
      WEIGHTS_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'h1000;
        endcase
      end
      default: return random_weight(weight_style_t'($urandom_range(0, 3)));
    endcase
  endfunction

  function automatic logic [15:0] random_feature();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 16383) - 8192);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_weights(input weights_t w);
    for (int j = 0; j < NUM_HIDDEN; j++) begin
      cfg_write(REG_HID_FIRST + CFG_IDX_W'(j),
                {16'($urandom), w.hid_wb[j], w.hid_wa[j], w.hid_bias[j]});
    end
    cfg_write(REG_OUT_LOW, {w.out_w[2], w.out_w[1], w.out_w[0], w.out_bias});
    cfg_write(REG_OUT_TOP, {48'({$urandom, $urandom}), w.out_w[NUM_HIDDEN-1]});
    cfg_write(REG_UNUSED_A, {$urandom, $urandom});
    cfg_write(REG_UNUSED_B, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input item_t x);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : receiver
    int gap;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      taken++;
    end
  end

  initial begin : stimulus
    weights_t      w;
    weight_style_t style;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 3; i++) begin
      send_item(item_t'(corner_items[i]));
    end
    item_valid <= 1'b0;
    settle();

    // Hidden neurons: relu(a), relu(b), relu(0.5 - a + b/4096) and one that clips both ways.
    w = '0;
    w.hid_wa[0]   = 16'h1000;
    w.hid_wb[1]   = 16'h1000;
    w.hid_bias[2] = 16'h0800;
    w.hid_wa[2]   = 16'hF000;
    w.hid_wb[2]   = 16'h0001;
    w.hid_bias[3] = 16'h8000;
    w.hid_wa[3]   = 16'h8000;
    w.hid_wb[3]   = 16'h8000;
    w.out_bias    = 16'hFF00;
    w.out_w[0]    = 16'h0800;
    w.out_w[1]    = 16'hF800;
    w.out_w[2]    = 16'h0400;
    w.out_w[3]    = 16'h0001;
    write_weights(w);
    for (int i = 0; i < CORNER_COUNT; i++) begin
      send_item(item_t'(corner_items[i]));
    end
    item_valid <= 1'b0;
    settle();

    w = {(4 * NUM_HIDDEN + 1){16'h7FFF}};
    write_weights(w);
    for (int i = 0; i < 4; i++) begin
      send_item(item_t'(corner_items[i]));
    end
    item_valid <= 1'b0;
    settle();

    w.out_w    = {NUM_HIDDEN{16'h8000}};
    w.out_bias = 16'h8000;
    write_weights(w);
    for (int i = 1; i < 5; i++) begin
      send_item(item_t'(corner_items[i]));
    end
    item_valid <= 1'b0;
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      style   = weight_style_t'(p % 5);
      no_gaps = (p == 3);
      for (int j = 0; j < NUM_HIDDEN; j++) begin
        w.hid_bias[j] = random_weight(style);
        w.hid_wa[j]   = random_weight(style);
        w.hid_wb[j]   = random_weight(style);
        w.out_w[j]    = random_weight(style);
      end
      w.out_bias = random_weight(style);
      write_weights(w);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(item_t'({random_feature(), random_feature()}));
      end
      item_valid <= 1'b0;
      settle();
    end

    no_gaps = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
